// File: hdl/rc4_pkg.sv
// ============================================================================
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher block.
// ============================================================================
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_SIZE         = 256;
    localparam int PERM_AW           = 8;
    localparam int DEF_MAX_KEY_BYTES = 256;

    // Request kind carried on s_axis_tuser; code 3 is ignored
    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_KEY   = 2'd1,
        ACT_RESET = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD,
        ST_KS_ADD1,
        ST_KS_ADD2,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_DT_RD_I,
        ST_DT_RD_J,
        ST_DT_WR_I,
        ST_DT_WR_J,
        ST_DT_RD_T,
        ST_DT_OUT
    } t_state;

    // One access to the permutation store per cycle
    typedef struct packed {
        logic                en;     // read or write
        logic                we;
        logic                clr;    // back to identity
        logic [PERM_AW-1:0]  addr;
        logic [BYTE_W-1:0]   wdata;
    } t_perm_req;

endpackage

// File: hdl/rc4_ram.sv
// ============================================================================
// rc4_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module rc4_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

// File: hdl/rc4_perm.sv
// ============================================================================
// rc4_perm
// Permutation store: RAM plus per-entry valid bits; an entry never written
// since the last clear reads as its own index (identity).
// ============================================================================
module rc4_perm
    import rc4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_perm_req         i_req,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [PERM_SIZE-1:0] r_vld;
    logic                 r_rd_vld;
    logic [PERM_AW-1:0]   r_rd_addr;
    logic [BYTE_W-1:0]    ram_q;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (i_req.en),
        .i_we    (i_req.we),
        .i_addr  (i_req.addr),
        .i_wdata (i_req.wdata),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.en && i_req.we) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rd_vld  <= r_vld[i_req.addr];
            r_rd_addr <= i_req.addr;
        end
    end

    assign o_rdata = r_rd_vld ? ram_q : BYTE_W'(r_rd_addr);

endmodule

// File: hdl/rc4_keystream_cipher_top.sv
// ============================================================================
// rc4_keystream_cipher_top
// RC4 stream cipher with byte-serial key load and in-block key schedule.
// ============================================================================
// Usage:
//   Input requests on s_axis: tdata is the byte, tlast marks the last key or
//   message byte, tuser is the kind (0 data, 1 key byte, 2 reset permutation).
//   Key bytes are stored (beyond MAX_KEY_BYTES they are dropped); a key byte
//   with tlast set resets the permutation and runs the key schedule.
//   Each data request returns one result on m_axis: tdata = byte XOR keystream,
//   tlast echoes the input tlast. Key and reset requests return nothing.
// Sequencing:
//   Data byte: states RD_I, RD_J, WR_I, WR_J, RD_T; OUT registers the result.
//   Last key byte: steps of RD, ADD1, ADD2, WR_K, WR_J, one per permutation
//   entry. Other key and reset requests complete in IDLE. The permutation RAM
//   is single-port: a data byte needs 3 reads and 2 writes, a schedule step
//   2 reads, 2 writes. s_axis_tready is high only between requests.
// Reset: i_rst_n (sync, active low) gives identity permutation, zero indices,
//   empty key. Key store contents are not cleared.
// Stall: the result register holds while m_axis_tready is low; a following
//   data request runs up to its result and then waits for the register.
// ============================================================================
module rc4_keystream_cipher_top
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CW  = $clog2(MAX_KEY_BYTES + 1);

    t_state            r_state, n_state;
    t_action           act;
    t_perm_req         perm_req;
    logic [BYTE_W-1:0] perm_rdata;

    logic              key_en, key_we;
    logic [KAW-1:0]    key_addr;
    logic [BYTE_W-1:0] key_q;

    logic [BYTE_W-1:0] add_a, add_b, add_sum;

    logic [PERM_AW-1:0] r_i, r_j;
    logic [CW-1:0]      r_key_count;
    logic [KAW-1:0]     r_pos;
    logic [BYTE_W-1:0]  r_acc, r_sa, r_sb, r_kb;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    logic               r_ovalid;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;

    logic in_acc, key_room, out_room, pos_wrap;

    assign act           = t_action'(s_axis_tuser);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign key_room      = r_key_count < CW'(MAX_KEY_BYTES);
    assign out_room      = !r_ovalid || m_axis_tready;
    assign pos_wrap      = (CW'(r_pos) + CW'(1)) >= r_key_count;

    // shared 8-bit adder
    assign add_sum = add_a + add_b;

    rc4_perm u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (perm_req),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_en    (key_en),
        .i_we    (key_we),
        .i_addr  (key_addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (key_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && act == ACT_DATA) begin
                    n_state = ST_DT_RD_I;
                end else if (in_acc && act == ACT_KEY && s_axis_tlast) begin
                    n_state = ST_KS_RD;
                end
            end
            ST_KS_RD:   n_state = ST_KS_ADD1;
            ST_KS_ADD1: n_state = ST_KS_ADD2;
            ST_KS_ADD2: n_state = ST_KS_WR_K;
            ST_KS_WR_K: n_state = ST_KS_WR_J;
            ST_KS_WR_J: n_state = (r_i == PERM_AW'(PERM_SIZE - 1)) ? ST_IDLE : ST_KS_RD;
            ST_DT_RD_I: n_state = ST_DT_RD_J;
            ST_DT_RD_J: n_state = ST_DT_WR_I;
            ST_DT_WR_I: n_state = ST_DT_WR_J;
            ST_DT_WR_J: n_state = ST_DT_RD_T;
            ST_DT_RD_T: n_state = ST_DT_OUT;
            ST_DT_OUT: begin
                if (out_room) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // per-state controls: memory ports and adder operands
    always_comb begin
        perm_req      = '0;
        key_en        = 1'b0;
        key_we        = 1'b0;
        key_addr      = r_pos;
        add_a         = r_i;
        add_b         = BYTE_W'(1);
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (act)
                        ACT_KEY: begin
                            key_en       = key_room;
                            key_we       = 1'b1;
                            key_addr     = r_key_count[KAW-1:0];
                            perm_req.clr = s_axis_tlast;
                        end
                        ACT_RESET: perm_req.clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_KS_RD: begin
                perm_req.en   = 1'b1;
                perm_req.addr = r_i;
                key_en        = 1'b1;
            end
            ST_KS_ADD1: begin
                add_a = r_j;
                add_b = perm_rdata;
            end
            ST_KS_ADD2: begin
                add_a         = r_acc;
                add_b         = r_kb;
                perm_req.en   = 1'b1;
                perm_req.addr = add_sum;
            end
            ST_KS_WR_K: begin
                perm_req.en    = 1'b1;
                perm_req.we    = 1'b1;
                perm_req.addr  = r_i;
                perm_req.wdata = perm_rdata;
            end
            ST_KS_WR_J: begin
                perm_req.en    = 1'b1;
                perm_req.we    = 1'b1;
                perm_req.addr  = r_j;
                perm_req.wdata = r_sa;
            end
            ST_DT_RD_I: begin
                perm_req.en   = 1'b1;
                perm_req.addr = add_sum;
            end
            ST_DT_RD_J: begin
                add_a         = r_j;
                add_b         = perm_rdata;
                perm_req.en   = 1'b1;
                perm_req.addr = add_sum;
            end
            ST_DT_WR_I: begin
                perm_req.en    = 1'b1;
                perm_req.we    = 1'b1;
                perm_req.addr  = r_i;
                perm_req.wdata = perm_rdata;
            end
            ST_DT_WR_J: begin
                perm_req.en    = 1'b1;
                perm_req.we    = 1'b1;
                perm_req.addr  = r_j;
                perm_req.wdata = r_sa;
            end
            ST_DT_RD_T: begin
                add_a         = r_sa;
                add_b         = r_sb;
                perm_req.en   = 1'b1;
                perm_req.addr = add_sum;
            end
            ST_DT_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_pos       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DT_OUT && out_room) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_byte <= s_axis_tdata;
                        r_last <= s_axis_tlast;
                        unique case (act)
                            ACT_KEY: begin
                                if (key_room) begin
                                    r_key_count <= r_key_count + CW'(1);
                                end
                                if (s_axis_tlast) begin
                                    r_i   <= '0;
                                    r_j   <= '0;
                                    r_pos <= '0;
                                end
                            end
                            ACT_RESET: begin
                                r_i <= '0;
                                r_j <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_KS_ADD1: begin
                    r_acc <= add_sum;
                    r_sa  <= perm_rdata;
                    r_kb  <= key_q;
                end
                ST_KS_ADD2: r_j <= add_sum;
                ST_KS_WR_J: begin
                    // r_i doubles as the schedule step and wraps back to zero
                    r_i   <= add_sum;
                    r_pos <= pos_wrap ? '0 : r_pos + KAW'(1);
                    if (r_i == PERM_AW'(PERM_SIZE - 1)) begin
                        r_key_count <= '0;
                        r_j         <= '0;
                    end
                end
                ST_DT_RD_I: r_i <= add_sum;
                ST_DT_RD_J: begin
                    r_j  <= add_sum;
                    r_sa <= perm_rdata;
                end
                ST_DT_WR_I: r_sb <= perm_rdata;
                ST_DT_OUT: begin
                    if (out_room) begin
                        r_obyte <= r_byte ^ perm_rdata;
                        r_olast <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;

    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_WR_J && r_i == PERM_AW'(PERM_SIZE - 1)) |=>
        (r_state == ST_IDLE && r_i == '0 && r_j == '0 && r_key_count == '0))
        else $error("key schedule did not end with cleared indices and key");

    a_key_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= CW'(MAX_KEY_BYTES))
        else $error("key count above maximum");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_DT_OUT)
        else $error("result raised outside the output step");

    a_data_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && act == ACT_DATA) |=> r_state == ST_DT_RD_I)
        else $error("data request did not start the generator");

endmodule

// File: dv/rc4_keystream_cipher_top_tb.sv
// ============================================================================
// rc4_keystream_cipher_top_tb
// Self-checking bench for the RC4 keystream cipher: drives key, data, reset
// and unused requests on s_axis, keeps its own copy of the permutation and
// indices, and checks every m_axis result in order against that copy.
// ============================================================================
module rc4_keystream_cipher_top_tb;
    import rc4_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         KEY_MAX    = DEF_MAX_KEY_BYTES;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_cipher_out;

    // Cipher state mirror plus the queue of bytes still owed by the block
    class rc4_scoreboard;
        bit [7:0]    perm [PERM_SIZE];
        bit [7:0]    key_bytes [PERM_SIZE];
        int unsigned key_len;
        bit [7:0]    idx_i;
        bit [7:0]    idx_j;
        t_cipher_out owed_bytes [$];
        int          errors;

        function new();
            foreach (key_bytes[k]) key_bytes[k] = '0;
            key_len = 0;
            errors  = 0;
            to_identity();
        endfunction

        function void to_identity();
            foreach (perm[k]) perm[k] = k[7:0];
            idx_i = '0;
            idx_j = '0;
        endfunction

        function void swap_perm(bit [7:0] a, bit [7:0] b);
            bit [7:0] t;
            t       = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
        endfunction

        function void key_schedule();
            bit [7:0]    j;
            int unsigned pos;
            to_identity();
            j   = '0;
            pos = 0;
            for (int k = 0; k < PERM_SIZE; k++) begin
                j = j + perm[k] + key_bytes[pos];
                swap_perm(k[7:0], j);
                pos++;
                if (pos >= key_len) pos = 0;
            end
            key_len = 0;
        endfunction

        function void note_request(logic [1:0] act, logic [7:0] din, logic last);
            t_cipher_out res;
            bit [7:0]    ks;
            case (act)
                ACT_DATA: begin
                    idx_i = idx_i + 8'd1;
                    idx_j = idx_j + perm[idx_i];
                    swap_perm(idx_i, idx_j);
                    ks = perm[8'(perm[idx_i] + perm[idx_j])];
                    res.out_byte = din ^ ks;
                    res.out_last = last;
                    owed_bytes.push_back(res);
                end
                ACT_KEY: begin
                    // bytes past the key limit are dropped, tlast still counts
                    if (key_len < KEY_MAX) begin
                        key_bytes[key_len] = din;
                        key_len++;
                    end
                    if (last) key_schedule();
                end
                ACT_RESET: to_identity();
                default: ;
            endcase
        endfunction

        task mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] got_byte, logic got_last);
            t_cipher_out want;
            if (owed_bytes.size() == 0) begin
                mismatch($sformatf("unexpected result byte %02h last %0b",
                                   got_byte, got_last));
            end else begin
                want = owed_bytes.pop_front();
                if (got_byte !== want.out_byte)
                    mismatch($sformatf("out_byte got %02h want %02h",
                                       got_byte, want.out_byte));
                if (got_last !== want.out_last)
                    mismatch($sformatf("out_last got %0b want %0b",
                                       got_last, want.out_last));
            end
        endtask

        task check_drained();
            if (owed_bytes.size() != 0)
                mismatch($sformatf("%0d results never arrived", owed_bytes.size()));
        endtask

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic [1:0] s_axis_tuser;   // [1:0] action
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;

    rc4_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            sent_items;

    rc4_keystream_cipher_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // Called at a falling edge; returns at the falling edge after the accept
    task automatic send_req(logic [1:0] act, logic [7:0] din, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= din;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (act != ACT_UNUSED) sent_items++;
    endtask

    task automatic key_then_message(int klen, int mlen);
        for (int k = 0; k < klen; k++)
            send_req(ACT_KEY, 8'($urandom), k == klen - 1);
        for (int k = 0; k < mlen; k++)
            send_req(ACT_DATA, 8'($urandom), k == mlen - 1);
    endtask

    task automatic random_phase(int tx_pct, int rx_pct, int quota);
        int stop_at;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = sent_items + quota;
        while (sent_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 2)
                key_then_message($urandom_range(300, 257), $urandom_range(24, 1));
            else if (pick < 5)
                key_then_message($urandom_range(256, 200), $urandom_range(24, 1));
            else if (pick < 80)
                key_then_message($urandom_range(16, 1), $urandom_range(24, 1));
            else if (pick < 88)
                repeat ($urandom_range(8, 1))
                    send_req(ACT_DATA, 8'($urandom), 1'($urandom_range(1)));
            else if (pick < 93)
                send_req(ACT_RESET, 8'($urandom), 1'($urandom_range(1)));
            else if (pick < 97)
                send_req(ACT_KEY, 8'($urandom), 1'b0);
            else
                send_req(ACT_UNUSED, 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        sb            = new();
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        sent_items    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_DATA;
        s_axis_tlast  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity permutation straight out of reset
        send_req(ACT_DATA, 8'h00, 1'b0);
        send_req(ACT_DATA, 8'hFF, 1'b1);
        send_req(ACT_UNUSED, 8'hA5, 1'b1);
        send_req(ACT_RESET, 8'h5A, 1'b0);
        send_req(ACT_DATA, 8'h3C, 1'b0);
        // one-byte key
        send_req(ACT_KEY, 8'h00, 1'b1);
        send_req(ACT_DATA, 8'h55, 1'b0);
        send_req(ACT_DATA, 8'hAA, 1'b1);
        // three-byte key with extreme values
        send_req(ACT_KEY, 8'hFF, 1'b0);
        send_req(ACT_KEY, 8'h01, 1'b0);
        send_req(ACT_KEY, 8'h80, 1'b1);
        send_req(ACT_DATA, 8'hFF, 1'b0);
        send_req(ACT_DATA, 8'h00, 1'b1);
        // hold off until the block has drained
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        // reset request in the middle of a key keeps the bytes loaded so far
        send_req(ACT_KEY, 8'h11, 1'b0);
        send_req(ACT_RESET, 8'h00, 1'b1);
        send_req(ACT_DATA, 8'h77, 1'b0);
        send_req(ACT_KEY, 8'h22, 1'b1);
        send_req(ACT_DATA, 8'h77, 1'b1);
        send_req(ACT_DATA, 8'h01, 1'b0);

        // full-length key, then three bytes past the limit
        tx_idle_pct = 15;
        rx_idle_pct = 74;
        key_then_message(KEY_MAX, 4);
        key_then_message(KEY_MAX + 3, 4);
        random_phase(15, 74, 320);
        random_phase(74, 15, 320);
        random_phase(0, 0, 320);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
